/* hw/rtl/ptmd_pkg.sv */
package ptmd_pkg;

   localparam int LINE_WIDTH_DEFAULT = 26;
   localparam int TAB_STEP_DEFAULT   = 8;

   // at most this many spaces come from one tab byte
   localparam int TAB_MAX_SPACES = 8;

   localparam logic [5:0] ROWS_LIMIT_RESET = 6'd30;
   localparam logic [5:0] ROW_MAX          = 6'd63;

   localparam logic [1:0] KIND_GLYPH    = 2'd0;
   localparam logic [1:0] KIND_ROW_END  = 2'd1;
   localparam logic [1:0] KIND_TEXT_END = 2'd2;

   localparam logic [2:0] COLOUR_GRAY   = 3'd0;
   localparam logic [2:0] COLOUR_WHITE  = 3'd1;
   localparam logic [2:0] COLOUR_GREEN  = 3'd2;
   localparam logic [2:0] COLOUR_YELLOW = 3'd3;
   localparam logic [2:0] COLOUR_RED    = 3'd4;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_V     = 8'h56;
   localparam logic [7:0] CHAR_W     = 8'h57;
   localparam logic [7:0] CHAR_X     = 8'h58;
   localparam logic [7:0] CHAR_Y     = 8'h59;
   localparam logic [7:0] CHAR_Z     = 8'h5A;
   localparam logic [7:0] CHAR_LBRK  = 8'h5B;
   localparam logic [7:0] CHAR_RBRK  = 8'h5D;
   localparam logic [7:0] CHAR_CARET = 8'h5E;

   // 'A' maps to code 10
   localparam logic [7:0] LETTER_OFFSET = 8'd55;

   localparam logic [7:0] INV_MASK = 8'h80;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       new_file;
   } item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] glyph;
      logic [2:0] colour;
      logic [5:0] row;
      logic [5:0] column;
      logic       last;
   } rsp_type;

   // handshake status from the decode core toward the channel registers
   typedef struct packed {
      logic step_done;
      logic res_load;
   } core_status_type;

endpackage

/* hw/rtl/ptmd_core.sv */
module ptmd_core #(
   parameter int LINE_WIDTH = ptmd_pkg::LINE_WIDTH_DEFAULT,
   parameter int TAB_STEP   = ptmd_pkg::TAB_STEP_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       item_valid,
   input  ptmd_pkg::item_type         item,
   input  logic                       out_ready,
   input  logic [5:0]                 rows_limit,
   output ptmd_pkg::core_status_type  status,
   output ptmd_pkg::rsp_type          res
);

   localparam int PW = (TAB_STEP > 1) ? $clog2(TAB_STEP) : 1;

   logic [5:0]    col_ff, col_in;
   logic [5:0]    row_ff, row_in;
   logic [2:0]    colour_ff, colour_in;
   logic          inv_ff, inv_in;
   logic          caret_ff, caret_in;
   logic          skip_ff, skip_in;
   logic          fin_ff, fin_in;
   logic [PW-1:0] phase_ff, phase_in;
   logic [2:0]    tab_cnt_ff, tab_cnt_in;
   logic          fin_pend_ff, fin_pend_in;

   logic          first_step, clr;
   logic [5:0]    e_col, e_row;
   logic [2:0]    e_colour;
   logic          e_inv, e_caret, e_skip, e_fin;
   logic [PW-1:0] e_phase;
   logic [7:0]    b;

   logic          has_res, final_step, place_en, is_tab, advance;
   logic [7:0]    code;
   logic [5:0]    ncol, row_next;
   logic          nskip, cont;
   logic [PW:0]   phase_inc;
   logic [PW-1:0] nphase;

   assign b          = item.text_byte;
   assign first_step = !fin_pend_ff && (tab_cnt_ff == 3'd0);
   assign clr        = item.new_file && first_step;

   assign e_col    = clr ? 6'd0 : col_ff;
   assign e_row    = clr ? 6'd0 : row_ff;
   assign e_colour = clr ? ptmd_pkg::COLOUR_GRAY : colour_ff;
   assign e_inv    = clr ? 1'b0 : inv_ff;
   assign e_caret  = clr ? 1'b0 : caret_ff;
   assign e_skip   = clr ? 1'b0 : skip_ff;
   assign e_fin    = clr ? 1'b0 : fin_ff;
   assign e_phase  = clr ? '0 : phase_ff;

   assign ncol      = e_col + 6'd1;
   assign nskip     = ncol >= 6'(LINE_WIDTH);
   assign phase_inc = {1'b0, e_phase} + (PW+1)'(1);
   assign nphase    = (phase_inc == (PW+1)'(TAB_STEP)) ? '0 : phase_inc[PW-1:0];
   assign row_next  = (e_row != ptmd_pkg::ROW_MAX) ? e_row + 6'd1 : e_row;
   assign cont      = (tab_cnt_ff != 3'(ptmd_pkg::TAB_MAX_SPACES - 1))
                      && !nskip && (nphase != '0);

   always_comb begin
      col_in      = e_col;
      row_in      = e_row;
      colour_in   = e_colour;
      inv_in      = e_inv;
      caret_in    = e_caret;
      skip_in     = e_skip;
      fin_in      = e_fin;
      phase_in    = e_phase;
      tab_cnt_in  = 3'd0;
      fin_pend_in = 1'b0;
      has_res     = 1'b0;
      final_step  = 1'b1;
      place_en    = 1'b0;
      is_tab      = 1'b0;
      code        = b;
      res.kind    = ptmd_pkg::KIND_GLYPH;
      res.glyph   = 8'd0;
      res.colour  = ptmd_pkg::COLOUR_GRAY;
      res.row     = e_row;
      res.column  = e_col;
      res.last    = 1'b1;

      if (fin_pend_ff) begin
         has_res    = 1'b1;
         res.kind   = ptmd_pkg::KIND_TEXT_END;
         res.column = 6'd0;
         fin_in     = 1'b1;
      end else if (e_fin || b == ptmd_pkg::CHAR_CR) begin
         has_res = 1'b0;
      end else if (b == ptmd_pkg::CHAR_LF || b == ptmd_pkg::CHAR_NUL) begin
         has_res   = 1'b1;
         res.kind  = ptmd_pkg::KIND_ROW_END;
         row_in    = row_next;
         col_in    = 6'd0;
         phase_in  = '0;
         colour_in = ptmd_pkg::COLOUR_GRAY;
         inv_in    = 1'b0;
         caret_in  = 1'b0;
         skip_in   = 1'b0;
         if (b == ptmd_pkg::CHAR_NUL || row_next >= rows_limit) begin
            fin_pend_in = 1'b1;
            final_step  = 1'b0;
            res.last    = 1'b0;
         end
      end else if (e_skip) begin
         has_res = 1'b0;
      end else if (e_caret) begin
         caret_in = 1'b0;
         if (b == ptmd_pkg::CHAR_W) begin
            colour_in = ptmd_pkg::COLOUR_WHITE;
         end else if (b == ptmd_pkg::CHAR_X) begin
            colour_in = ptmd_pkg::COLOUR_GREEN;
         end else if (b == ptmd_pkg::CHAR_Y) begin
            colour_in = ptmd_pkg::COLOUR_YELLOW;
         end else if (b == ptmd_pkg::CHAR_Z) begin
            colour_in = ptmd_pkg::COLOUR_RED;
         end else if (b == ptmd_pkg::CHAR_ZERO) begin
            colour_in = ptmd_pkg::COLOUR_GRAY;
         end else if (b >= ptmd_pkg::CHAR_ONE && b <= ptmd_pkg::CHAR_NINE) begin
            place_en = 1'b1;
            code     = b - ptmd_pkg::CHAR_ZERO;
         end else if (b >= ptmd_pkg::CHAR_A && b <= ptmd_pkg::CHAR_V) begin
            place_en = 1'b1;
            code     = b - ptmd_pkg::LETTER_OFFSET;
         end else if (b == ptmd_pkg::CHAR_LBRK) begin
            inv_in = 1'b1;
         end else if (b == ptmd_pkg::CHAR_RBRK) begin
            inv_in = 1'b0;
         end else begin
            place_en = 1'b1;
         end
      end else if (b == ptmd_pkg::CHAR_CARET) begin
         caret_in = 1'b1;
      end else if (b == ptmd_pkg::CHAR_TAB) begin
         place_en = 1'b1;
         is_tab   = 1'b1;
         code     = ptmd_pkg::CHAR_SPACE;
      end else begin
         place_en = 1'b1;
      end

      if (place_en) begin
         has_res    = 1'b1;
         res.kind   = ptmd_pkg::KIND_GLYPH;
         res.glyph  = code ^ (e_inv ? ptmd_pkg::INV_MASK : 8'd0);
         res.colour = e_colour;
         col_in     = ncol;
         phase_in   = nphase;
         skip_in    = nskip;
         if (is_tab && cont) begin
            tab_cnt_in = tab_cnt_ff + 3'd1;
            final_step = 1'b0;
            res.last   = 1'b0;
         end
      end
   end

   assign advance          = !has_res || out_ready;
   assign status.step_done = item_valid && advance && final_step;
   assign status.res_load  = item_valid && has_res && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= 6'd0;
         row_ff      <= 6'd0;
         colour_ff   <= ptmd_pkg::COLOUR_GRAY;
         inv_ff      <= 1'b0;
         caret_ff    <= 1'b0;
         skip_ff     <= 1'b0;
         fin_ff      <= 1'b0;
         phase_ff    <= '0;
         tab_cnt_ff  <= 3'd0;
         fin_pend_ff <= 1'b0;
      end else if (item_valid && advance) begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         colour_ff   <= colour_in;
         inv_ff      <= inv_in;
         caret_ff    <= caret_in;
         skip_ff     <= skip_in;
         fin_ff      <= fin_in;
         phase_ff    <= phase_in;
         tab_cnt_ff  <= tab_cnt_in;
         fin_pend_ff <= fin_pend_in;
      end
   end

endmodule

/* hw/rtl/ptmd_out_reg.sv */
module ptmd_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  ptmd_pkg::rsp_type res,
   input  logic              rsp_stall,
   output logic              out_ready,
   output logic              rsp_valid,
   output ptmd_pkg::rsp_type rsp_data
);

   logic              valid_ff;
   ptmd_pkg::rsp_type data_ff;

   // take a new result when empty or when the held one leaves
   assign out_ready = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_ready) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && load) begin
         data_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

/* hw/rtl/preview_text_markup_decoder.sv */
// Path: an accepted byte sits in the input register; each result is registered in the result register.
// Throughput: one result per cycle while the receiver does not stall; a byte makes one or
//   more results (a tab up to 8, a line feed or zero byte that ends the text 2), or none.
//   The decode core places one glyph or event per cycle unless a held result is stalled.
// Reset: synchronous, active high; clears row, column, mode and done state, empties
//   both channel registers and loads rows_limit with 30.
module preview_text_markup_decoder #(
   parameter int LINE_WIDTH = ptmd_pkg::LINE_WIDTH_DEFAULT,
   parameter int TAB_STEP   = ptmd_pkg::TAB_STEP_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       req_new_file,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_glyph,
   output logic [2:0] rsp_colour,
   output logic [5:0] rsp_row,
   output logic [5:0] rsp_column,
   output logic       rsp_last,

   input  logic       csr_wr_en,
   input  logic [5:0] csr_wr_data
);

   logic                      item_valid_ff;
   ptmd_pkg::item_type        item_ff;
   logic [5:0]                rows_limit_ff;
   ptmd_pkg::core_status_type status;
   ptmd_pkg::rsp_type         res;
   ptmd_pkg::rsp_type         rsp_data;
   logic                      out_ready;

   // Rows-limit register; the user must write it only while the decoder is idle; the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_limit_ff <= ptmd_pkg::ROWS_LIMIT_RESET;
      end else if (csr_wr_en) begin
         rows_limit_ff <= csr_wr_data;
      end
   end

   // Input register: hold the byte until its last result is loaded (or it
   // turns out to make none); take the next transaction in that same cycle.
   assign req_stall = item_valid_ff && !status.step_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff.text_byte <= req_text_byte;
         item_ff.new_file  <= req_new_file;
      end
   end

   // Decode core: text state plus one step of decode per cycle unless a held result is stalled.
   ptmd_core #(
      .LINE_WIDTH (LINE_WIDTH),
      .TAB_STEP   (TAB_STEP)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid_ff),
      .item       (item_ff),
      .out_ready  (out_ready),
      .rows_limit (rows_limit_ff),
      .status     (status),
      .res        (res)
   );

   // Result register: parts the core from a stalled receiver.
   ptmd_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (status.res_load),
      .res       (res),
      .rsp_stall (rsp_stall),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind   = rsp_data.kind;
   assign rsp_glyph  = rsp_data.glyph;
   assign rsp_colour = rsp_data.colour;
   assign rsp_row    = rsp_data.row;
   assign rsp_column = rsp_data.column;
   assign rsp_last   = rsp_data.last;

endmodule

/* hw/rtl/ptmd_checker.sv */
module ptmd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_glyph,
   input logic [2:0] rsp_colour,
   input logic [5:0] rsp_row,
   input logic [5:0] rsp_column,
   input logic       rsp_last
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_glyph)
         && $stable(rsp_row) && $stable(rsp_column) && $stable(rsp_last))
      else $error("rsp transaction changed while stalled");

   // text end closes the byte's results
   a_text_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == ptmd_pkg::KIND_TEXT_END |-> rsp_last && rsp_column == 6'd0)
      else $error("text end result not last or column not zero");

   // events carry no glyph or colour
   a_event_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != ptmd_pkg::KIND_GLYPH
         |-> rsp_glyph == 8'd0 && rsp_colour == ptmd_pkg::COLOUR_GRAY)
      else $error("row or text event with glyph or colour");

   // a row end that is not last is followed by the text end
   a_row_end_then_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_kind == ptmd_pkg::KIND_ROW_END && !rsp_last
         ##1 rsp_valid |-> rsp_kind == ptmd_pkg::KIND_TEXT_END)
      else $error("row end without following text end");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind preview_text_markup_decoder ptmd_checker u_ptmd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_kind   (rsp_kind),
   .rsp_glyph  (rsp_glyph),
   .rsp_colour (rsp_colour),
   .rsp_row    (rsp_row),
   .rsp_column (rsp_column),
   .rsp_last   (rsp_last)
);

/* tb/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // one byte never yields more than this many panel events
   localparam int MAX_EVENTS = 8;
   // cycles with no transaction on either channel before the run is declared hung
   localparam int HANG_LIMIT = 2000;
   // quiet cycles covering a byte still in flight that yields no event
   localparam int SETTLE_CYCLES = 6;

   logic       clock = 1'b0;
   logic       reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_text_byte = '0;
   logic       req_new_file = 1'b0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_glyph;
   logic [2:0] rsp_colour;
   logic [5:0] rsp_row;
   logic [5:0] rsp_column;
   logic       rsp_last;

   logic       csr_wr_en = 1'b0;
   logic [5:0] csr_wr_data = '0;

   preview_text_markup_decoder u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_text_byte(req_text_byte),
      .req_new_file (req_new_file),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_glyph    (rsp_glyph),
      .rsp_colour   (rsp_colour),
      .rsp_row      (rsp_row),
      .rsp_column   (rsp_column),
      .rsp_last     (rsp_last),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Decoder shadow: row/column position, colour and mode flags, and the
   // row limit register, kept at the block's own widths.
   // ---------------------------------------------------------------------
   logic [5:0] shown_rows;
   logic [5:0] cur_column;
   logic [5:0] cur_row;
   logic [2:0] cur_colour;
   logic       inverse_video;
   logic       escape_open;
   logic       line_full;
   logic       text_done;

   ptmd_pkg::rsp_type byte_events[$];       // events of the byte being decoded
   ptmd_pkg::rsp_type panel_events_due[$];  // events still owed by the block, oldest first

   int         send_idle_pct  = 0;
   int         recv_stall_pct = 0;
   int         mismatch_count = 0;
   int         quiet_cycles   = 0;
   ptmd_pkg::rsp_type oldest_due;
   ptmd_pkg::rsp_type seen_event;

   function automatic void add_event(logic [1:0] kind, logic [7:0] glyph, logic [2:0] colour,
                                     logic [5:0] row, logic [5:0] column);
      ptmd_pkg::rsp_type ev;
      ev.kind   = kind;
      ev.glyph  = glyph;
      ev.colour = colour;
      ev.row    = row;
      ev.column = column;
      ev.last   = 1'b0;
      if (byte_events.size() < MAX_EVENTS) byte_events.push_back(ev);
   endfunction

   function automatic void clear_decode_state();
      cur_column    = '0;
      cur_row       = '0;
      cur_colour    = ptmd_pkg::COLOUR_GRAY;
      inverse_video = 1'b0;
      escape_open   = 1'b0;
      line_full     = 1'b0;
      text_done     = 1'b0;
   endfunction

   // put one glyph at the cursor, then advance; the line fills at the panel width
   function automatic void place_glyph(logic [7:0] code);
      add_event(ptmd_pkg::KIND_GLYPH, inverse_video ? (code ^ ptmd_pkg::INV_MASK) : code,
                cur_colour, cur_row, cur_column);
      cur_column = cur_column + 6'd1;
      if (cur_column >= ptmd_pkg::LINE_WIDTH_DEFAULT) line_full = 1'b1;
   endfunction

   function automatic void close_row(logic at_text_end);
      add_event(ptmd_pkg::KIND_ROW_END, 8'h00, ptmd_pkg::COLOUR_GRAY, cur_row, cur_column);
      if (cur_row < ptmd_pkg::ROW_MAX) cur_row = cur_row + 6'd1;
      cur_column    = '0;
      cur_colour    = ptmd_pkg::COLOUR_GRAY;
      inverse_video = 1'b0;
      escape_open   = 1'b0;
      line_full     = 1'b0;
      if (at_text_end || cur_row >= shown_rows) begin
         add_event(ptmd_pkg::KIND_TEXT_END, 8'h00, ptmd_pkg::COLOUR_GRAY, cur_row, 6'd0);
         text_done = 1'b1;
      end
   endfunction

   // work out every panel event one accepted byte causes and queue them
   function automatic void decode_text_byte(logic [7:0] b, logic new_file);
      ptmd_pkg::rsp_type ev;
      byte_events.delete();
      if (new_file) clear_decode_state();
      if (text_done || b == ptmd_pkg::CHAR_CR) return;

      if (b == ptmd_pkg::CHAR_LF || b == ptmd_pkg::CHAR_NUL) begin
         close_row(b == ptmd_pkg::CHAR_NUL);
      end else if (line_full) begin
         // drop everything up to the line feed
      end else if (escape_open) begin
         escape_open = 1'b0;
         case (b)
            ptmd_pkg::CHAR_W:    cur_colour = ptmd_pkg::COLOUR_WHITE;
            ptmd_pkg::CHAR_X:    cur_colour = ptmd_pkg::COLOUR_GREEN;
            ptmd_pkg::CHAR_Y:    cur_colour = ptmd_pkg::COLOUR_YELLOW;
            ptmd_pkg::CHAR_Z:    cur_colour = ptmd_pkg::COLOUR_RED;
            ptmd_pkg::CHAR_ZERO: cur_colour = ptmd_pkg::COLOUR_GRAY;
            ptmd_pkg::CHAR_LBRK: inverse_video = 1'b1;
            ptmd_pkg::CHAR_RBRK: inverse_video = 1'b0;
            default: begin
               if (b >= ptmd_pkg::CHAR_ONE && b <= ptmd_pkg::CHAR_NINE)
                  place_glyph(b - ptmd_pkg::CHAR_ZERO);
               else if (b >= ptmd_pkg::CHAR_A && b <= ptmd_pkg::CHAR_V)
                  place_glyph(b - ptmd_pkg::LETTER_OFFSET);
               else
                  place_glyph(b);
            end
         endcase
      end else if (b == ptmd_pkg::CHAR_CARET) begin
         escape_open = 1'b1;
      end else if (b == ptmd_pkg::CHAR_TAB) begin
         do
            place_glyph(ptmd_pkg::CHAR_SPACE);
         while (byte_events.size() < MAX_EVENTS && !line_full &&
                (cur_column % ptmd_pkg::TAB_STEP_DEFAULT) != 0);
      end else begin
         place_glyph(b);
      end

      foreach (byte_events[i]) begin
         ev = byte_events[i];
         ev.last = (i == byte_events.size() - 1);
         panel_events_due.push_back(ev);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driving helpers. Inputs change only at the falling edge; every helper
   // starts at the next falling edge so a valid is never sampled again once taken.
   // ---------------------------------------------------------------------

   // offer one byte, idling at random first; decode it once the transaction completes
   task automatic send_byte(logic [7:0] b, logic new_file);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      req_new_file  <= new_file;
      do @(posedge clock); while (req_stall);
      decode_text_byte(b, new_file);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   // drop valid and hold until every owed event has come out
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (panel_events_due.size() != 0) @(posedge clock);
   endtask

   // write the row limit only while the decoder is idle
   task automatic set_rows_limit(logic [5:0] rows);
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rows;
      @(posedge clock);
      shown_rows = rows;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Receiver side: random stall, check each result transaction in order
   // ---------------------------------------------------------------------
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   function automatic string event_text(ptmd_pkg::rsp_type ev);
      return $sformatf("kind=%0d glyph=%02h colour=%0d row=%0d col=%0d last=%0d",
                       ev.kind, ev.glyph, ev.colour, ev.row, ev.column, ev.last);
   endfunction

   task automatic report_mismatch(string what, ptmd_pkg::rsp_type want,
                                  ptmd_pkg::rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: expected %s, got %s", $time, what, event_text(want),
                  event_text(got));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_event = {rsp_kind, rsp_glyph, rsp_colour, rsp_row, rsp_column, rsp_last};
         if (panel_events_due.size() == 0) begin
            report_mismatch("event with none owed", '0, seen_event);
         end else begin
            oldest_due = panel_events_due.pop_front();
            if (seen_event.kind !== oldest_due.kind || seen_event.glyph !== oldest_due.glyph ||
                seen_event.colour !== oldest_due.colour || seen_event.row !== oldest_due.row ||
                seen_event.column !== oldest_due.column || seen_event.last !== oldest_due.last)
               report_mismatch("event mismatch", oldest_due, seen_event);
         end
      end
   end

   // hang detector: count cycles in which neither channel completes a transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("FAIL preview_text_markup_decoder");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // byte value extremes, a dropped carriage return, a row end
   task automatic test_plain_and_extremes();
      send_byte("H", 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(ptmd_pkg::CHAR_CR, 1'b0);
      send_byte(ptmd_pkg::CHAR_LF, 1'b0);
   endtask

   // colours, inversion, control codes, a literal caret, a caret that survives
   // a carriage return, and a caret swallowed by a line feed
   task automatic test_caret_escapes();
      send_text("^W^[");
      send_byte(8'h7F, 1'b0);
      send_text("^]^Z^9^A^^^q");
      send_byte(ptmd_pkg::CHAR_CARET, 1'b0);
      send_byte(ptmd_pkg::CHAR_CR, 1'b0);
      send_text("Y*");
      send_byte(ptmd_pkg::CHAR_CARET, 1'b0);
      send_byte(ptmd_pkg::CHAR_LF, 1'b0);
   endtask

   // full and partial tabs, then run past the panel width so the rest is dropped
   task automatic test_tab_and_overflow();
      send_byte(ptmd_pkg::CHAR_TAB, 1'b0);
      send_text("a");
      send_byte(ptmd_pkg::CHAR_TAB, 1'b0);
      send_byte(ptmd_pkg::CHAR_TAB, 1'b0);
      send_text("bcd^");
      send_byte(ptmd_pkg::CHAR_CR, 1'b0);
      send_byte(ptmd_pkg::CHAR_LF, 1'b0);
   endtask

   // zero byte ends the text; input is ignored until the next file starts
   task automatic test_text_end();
      send_text("e");
      send_byte(ptmd_pkg::CHAR_NUL, 1'b0);
      send_text("f");
      send_byte(ptmd_pkg::CHAR_LF, 1'b0);
      send_byte("g", 1'b1);
      send_byte(ptmd_pkg::CHAR_CARET, 1'b0);
      send_byte(ptmd_pkg::CHAR_NUL, 1'b0);
      send_byte(ptmd_pkg::CHAR_LF, 1'b1);
   endtask

   // a row limit of one row and the largest row limit
   task automatic test_row_limit();
      set_rows_limit(6'd1);
      send_text("ab");
      send_byte(ptmd_pkg::CHAR_LF, 1'b0);
      send_text("c");
      send_byte(ptmd_pkg::CHAR_LF, 1'b1);
      set_rows_limit(6'd63);
      send_byte(ptmd_pkg::CHAR_LF, 1'b1);
      repeat (62) send_byte(ptmd_pkg::CHAR_LF, 1'b0);
      send_byte(ptmd_pkg::CHAR_LF, 1'b0);
   endtask

   // mostly well-formed rows with random content, some noise bytes and
   // unterminated rows; restart the file most of the time once it is done
   task automatic send_random_text(int item_goal);
      string      escapes = "0WXYZ123456789ABCDEFGHIJKLMNOPQRSTUV[]^a*";
      int         sent;
      int         line_len;
      int         pick;
      logic       new_file;
      logic       escape_next;
      logic [7:0] b;
      sent = 0;
      escape_next = 1'b0;
      while (sent < item_goal) begin
         line_len = ($urandom_range(5) == 0) ? $urandom_range(20, 36) : $urandom_range(0, 10);
         for (int i = 0; i <= line_len; i++) begin
            new_file = (text_done && $urandom_range(9) < 8) || $urandom_range(49) == 0;
            pick = $urandom_range(99);
            if (escape_next) begin
               escape_next = 1'b0;
               b = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                            : escapes[$urandom_range(escapes.len() - 1)];
            end else if (i == line_len && pick < 85) begin
               b = ptmd_pkg::CHAR_LF;
            end else if (i == line_len && pick < 92) begin
               b = ptmd_pkg::CHAR_NUL;
            end else if (pick < 14) begin
               b = ptmd_pkg::CHAR_CARET;
               escape_next = 1'b1;
            end else if (pick < 22) begin
               b = ptmd_pkg::CHAR_TAB;
            end else if (pick < 26) begin
               b = ptmd_pkg::CHAR_CR;
            end else if (pick < 32) begin
               b = 8'($urandom_range(255));
            end else begin
               b = 8'($urandom_range(32, 126));
            end
            // bytes dropped while the text is done do not count
            if (!text_done || new_file) sent++;
            send_byte(b, new_file);
         end
      end
   endtask

   task automatic test_random_text(logic [5:0] rows, int item_goal);
      set_rows_limit(rows);
      send_random_text(item_goal / 2);
      // pause the sender until the block has emptied out
      hold_until_drained();
      send_random_text(item_goal - item_goal / 2);
   endtask

   initial begin
      shown_rows = ptmd_pkg::ROWS_LIMIT_RESET;
      clear_decode_state();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender rarely idles, receiver stalls most of the time
      send_idle_pct  = 7;
      recv_stall_pct = 87;
      test_plain_and_extremes();
      test_caret_escapes();
      test_tab_and_overflow();
      test_text_end();
      test_row_limit();
      test_random_text(6'($urandom_range(2, 8)), 36);

      // sender idles most of the time, receiver rarely stalls
      send_idle_pct  = 87;
      recv_stall_pct = 7;
      test_random_text(6'($urandom_range(9, 62)), 35);

      // full rate on both sides
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_text(ptmd_pkg::ROWS_LIMIT_RESET, 35);

      hold_until_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && panel_events_due.size() == 0) begin
         $display("PASS preview_text_markup_decoder");
      end else begin
         $display("FAIL preview_text_markup_decoder");
      end
      $finish;
   end

endmodule
